### sv/pbsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsa_pkg
// Shared types and constants for the paged bitmap slot allocator.
// ----------------------------------------------------------------------------
package pbsa_pkg;

  localparam int UNITS_MAX_DEF = 32;
  localparam int PAGES_MAX_DEF = 16;
  localparam int IDX_W = 9;
  localparam int CMD_W = 3;
  localparam int UPP_W = 6;

  typedef enum logic [2:0] {
    CMD_TAKE_AT    = 3'd0,
    CMD_REQUEST    = 3'd1,
    CMD_RELEASE    = 3'd2,
    CMD_RECLAIM    = 3'd3,
    CMD_QUERY      = 3'd4,
    CMD_CLEAR_KEEP = 3'd5,
    CMD_CLEAR_DROP = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SLOT  = 2'd1,
    ST_RANGE = 2'd2,
    ST_ROOM  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_EXEC,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic exec;
    logic clear_step;
    logic out_load;
  } ctl_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic clear_done;
    logic is_request;
    logic is_clear;
  } sts_t;

endpackage

### sv/pbsa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsa_ctrl
// Sequencer: divide, scan or clear sweep, execute, present result.
// ----------------------------------------------------------------------------
module pbsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output pbsa_pkg::ctl_t ctl,
  input  pbsa_pkg::sts_t sts
);
  import pbsa_pkg::*;

  state_t state, state_next;
  logic   out_busy;
  logic   out_busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_busy <= 1'b0;
    end else begin
      state    <= state_next;
      out_busy <= out_busy_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.is_request) state_next = S_SCAN;
          else if (sts.is_clear) state_next = S_CLEAR;
          else state_next = S_EXEC;
        end
      end
      S_SCAN:  if (sts.scan_done) state_next = S_EXEC;
      S_CLEAR: if (sts.clear_done) state_next = S_EXEC;
      S_EXEC:  state_next = S_DONE;
      S_DONE:  if (!out_busy || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      S_DIV:   ctl.div_step = 1'b1;
      S_SCAN:  ctl.scan_step = 1'b1;
      S_CLEAR: ctl.clear_step = 1'b1;
      S_EXEC:  ctl.exec = 1'b1;
      S_DONE:  ctl.out_load = !out_busy || out_ready;
      default: ;
    endcase
  end

  always_comb begin
    out_busy_next = out_busy;
    if (out_busy && out_ready) out_busy_next = 1'b0;
    if (ctl.out_load) out_busy_next = 1'b1;
  end

  assign out_valid = out_busy;

endmodule

### sv/pbsa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbsa_dp
// Page directory, usage bitmaps, divider, request scan and result register.
// ----------------------------------------------------------------------------
module pbsa_dp #(
  parameter int UNITS_MAX = pbsa_pkg::UNITS_MAX_DEF,
  parameter int PAGES_MAX = pbsa_pkg::PAGES_MAX_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pbsa_pkg::CMD_W-1:0]  cmd,
  input  logic [pbsa_pkg::IDX_W-1:0]  index,
  input  logic [pbsa_pkg::UPP_W-1:0]  upp_reg,
  input  pbsa_pkg::ctl_t              ctl,
  output pbsa_pkg::sts_t              sts,
  output logic [1:0]                  status,
  output logic [pbsa_pkg::IDX_W-1:0]  granted_index,
  output logic                        slot_taken,
  output logic [pbsa_pkg::IDX_W:0]    total_used,
  output logic [$clog2(PAGES_MAX+1)-1:0] pages_in_use
);
  import pbsa_pkg::*;

  localparam int PW  = (PAGES_MAX > 1) ? $clog2(PAGES_MAX) : 1;
  localparam int PCW = $clog2(PAGES_MAX + 1);
  localparam int SW  = (UNITS_MAX > 1) ? $clog2(UNITS_MAX) : 1;
  localparam int UW  = $clog2(UNITS_MAX + 1);
  localparam int TW  = IDX_W + 1;
  localparam int DW  = IDX_W + UW;
  localparam int BW  = $clog2(IDX_W + 1);

  logic [PAGES_MAX-1:0] present;
  logic [UNITS_MAX-1:0] umap [PAGES_MAX];
  logic [UW-1:0]        used [PAGES_MAX];
  logic [TW-1:0]        total;
  logic [PCW-1:0]       pcount;

  logic [CMD_W-1:0] cmd_r;
  logic [IDX_W-1:0] idx_r;
  logic [UW-1:0]    upp;
  logic [IDX_W-1:0] quo;
  logic [UW-1:0]    rem;
  logic [BW-1:0]    bit_cnt;

  logic [PCW-1:0]   scan_p;
  logic             found, absent_seen;
  logic [PW-1:0]    gp, ap;
  logic [SW-1:0]    gs;
  logic [PW-1:0]    clr_p;

  // Effective slots per page
  logic [UW-1:0] upp_eff;
  always_comb begin
    if (upp_reg == '0) upp_eff = UW'(1);
    else if ({{(32-UPP_W){1'b0}}, upp_reg} > UNITS_MAX) upp_eff = UW'(UNITS_MAX);
    else upp_eff = UW'(upp_reg);
  end

  // Restoring divider, one quotient bit a cycle
  logic [UW:0] rem_sh;
  assign rem_sh = {rem, idx_r[IDX_W-1 - bit_cnt[BW-1:0]]};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= cmd;
      idx_r   <= index;
      upp     <= upp_eff;
      rem     <= '0;
      quo     <= '0;
      bit_cnt <= '0;
    end else if (ctl.div_step && bit_cnt != BW'(IDX_W)) begin
      if (rem_sh >= {1'b0, upp}) begin
        rem <= UW'(rem_sh - {1'b0, upp});
        quo <= {quo[IDX_W-2:0], 1'b1};
      end else begin
        rem <= UW'(rem_sh);
        quo <= {quo[IDX_W-2:0], 1'b0};
      end
      bit_cnt <= bit_cnt + BW'(1);
    end
  end

  logic is_req, is_clr;
  assign is_req = cmd_r == CMD_REQUEST;
  assign is_clr = (cmd_r == CMD_CLEAR_KEEP) || (cmd_r == CMD_CLEAR_DROP);
  assign sts.div_done   = bit_cnt == BW'(IDX_W);
  assign sts.is_request = is_req;
  assign sts.is_clear   = is_clr;

  // Decoded page and slot
  logic          in_range;
  logic [PW-1:0] page;
  logic [SW-1:0] slot;
  assign in_range = {{(32-IDX_W){1'b0}}, quo} < PAGES_MAX;
  assign page     = quo[PW-1:0];
  assign slot     = rem[SW-1:0];

  // Mask of active slots
  logic [UNITS_MAX-1:0] act_mask;
  always_comb begin
    for (int i = 0; i < UNITS_MAX; i++) act_mask[i] = (UW'(i) < upp);
  end

  // Request scan, one page a cycle
  logic [PW-1:0]        sp;
  logic [UNITS_MAX-1:0] free_bits;
  logic                 any_free;
  logic [SW-1:0]        first_free;
  assign sp        = scan_p[PW-1:0];
  assign free_bits = ~umap[sp] & act_mask;
  assign any_free  = |free_bits;
  always_comb begin
    first_free = '0;
    for (int i = UNITS_MAX - 1; i >= 0; i--) if (free_bits[i]) first_free = SW'(i);
  end
  logic scan_end;
  assign scan_end = found || scan_p >= pcount || {{(32-PCW){1'b0}}, scan_p} >= PAGES_MAX;
  assign sts.scan_done = scan_end;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scan_p      <= '0;
      found       <= 1'b0;
      absent_seen <= 1'b0;
      gp          <= '0;
      ap          <= '0;
      gs          <= '0;
      clr_p       <= '0;
    end else if (ctl.scan_step && !scan_end) begin
      if (!present[sp]) begin
        if (!absent_seen) begin
          absent_seen <= 1'b1;
          ap          <= sp;
        end
      end else if (any_free) begin
        found <= 1'b1;
        gp    <= sp;
        gs    <= first_free;
      end
      scan_p <= scan_p + PCW'(1);
    end else if (ctl.clear_step) begin
      clr_p <= clr_p + PW'(1);
    end
  end
  assign sts.clear_done = {{(32-PW){1'b0}}, clr_p} == PAGES_MAX - 1;

  // Execute
  logic          tk;
  logic [PW-1:0] ep;
  logic [SW-1:0] es;
  logic          room;
  logic [PW-1:0] rp;
  logic [SW-1:0] rs;
  assign tk   = pcount < PCW'(PAGES_MAX) && {{(32-PCW){1'b0}}, pcount} < PAGES_MAX
                && pcount[PW-1:0] == pcount[PW-1:0];
  assign room = found || absent_seen || tk;
  always_comb begin
    if (found) begin
      rp = gp; rs = gs;
    end else if (absent_seen) begin
      rp = ap; rs = '0;
    end else begin
      rp = pcount[PW-1:0]; rs = '0;
    end
  end
  assign ep = is_req ? rp : page;
  assign es = is_req ? rs : slot;

  logic is_taken;
  assign is_taken = in_range && ({{(PCW-PW){1'b0}}, page} < pcount || PCW == PW)
                    && PCW'(page) < pcount && present[page] && umap[page][slot];

  logic [1:0]     st_v;
  logic [IDX_W-1:0] gi_v;
  logic           tk_v;
  logic [DW-1:0]  prod;
  assign prod = DW'(rp) * DW'(upp) + DW'(rs);

  // Response fields, staged at execute and held until the output is free
  logic [1:0]       res_st;
  logic [IDX_W-1:0] res_gi;
  logic             res_tk;

  always_comb begin
    st_v = ST_OK;
    gi_v = idx_r;
    tk_v = 1'b0;
    unique case (cmd_r)
      CMD_REQUEST: begin
        if (room) begin
          gi_v = IDX_W'(prod);
          tk_v = 1'b1;
        end else begin
          st_v = ST_ROOM;
          gi_v = '0;
        end
      end
      CMD_TAKE_AT: begin
        if (!in_range) st_v = ST_RANGE;
        else begin
          if (is_taken) st_v = ST_SLOT;
          tk_v = 1'b1;
        end
      end
      CMD_RELEASE, CMD_RECLAIM: begin
        if (!in_range) st_v = ST_RANGE;
        else if (!is_taken) st_v = ST_SLOT;
      end
      CMD_QUERY: begin
        if (!in_range) st_v = ST_RANGE;
        tk_v = is_taken;
      end
      CMD_CLEAR_KEEP, CMD_CLEAR_DROP: ;
      default: tk_v = is_taken;
    endcase
  end

  logic [UNITS_MAX-1:0] cur_map;
  logic [UW-1:0]        cur_used;
  always_comb begin
    cur_map  = present[ep] ? umap[ep] : '0;
    cur_used = present[ep] ? used[ep] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      total   <= '0;
      pcount  <= '0;
      for (int i = 0; i < PAGES_MAX; i++) begin
        umap[i] <= '0;
        used[i] <= '0;
      end
    end else if (ctl.clear_step) begin
      umap[clr_p] <= '0;
      used[clr_p] <= '0;
      if (cmd_r == CMD_CLEAR_DROP) present[clr_p] <= 1'b0;
    end else if (ctl.exec) begin
      unique case (cmd_r)
        CMD_REQUEST: begin
          if (room) begin
            present[rp] <= 1'b1;
            umap[rp]    <= cur_map | (UNITS_MAX'(1) << rs);
            used[rp]    <= cur_used + UW'(1);
            total       <= total + TW'(1);
            if (!found && !absent_seen) pcount <= pcount + PCW'(1);
          end
        end
        CMD_TAKE_AT: begin
          if (in_range && !is_taken) begin
            if (PCW'(page) >= pcount) begin
              for (int i = 0; i < PAGES_MAX; i++)
                if (PCW'(i) >= pcount && PW'(i) < page) present[i] <= 1'b0;
              pcount <= PCW'(page) + PCW'(1);
            end
            present[page] <= 1'b1;
            umap[page]    <= ((PCW'(page) < pcount && present[page]) ? umap[page] : '0)
                             | (UNITS_MAX'(1) << slot);
            used[page]    <= ((PCW'(page) < pcount && present[page]) ? used[page] : '0)
                             + UW'(1);
            total         <= total + TW'(1);
          end
        end
        CMD_RELEASE, CMD_RECLAIM: begin
          if (in_range && is_taken) begin
            total <= total - TW'(1);
            if (cmd_r == CMD_RECLAIM && used[page] == UW'(1)) begin
              present[page] <= 1'b0;
              umap[page]    <= '0;
              used[page]    <= '0;
              if (PCW'(page) + PCW'(1) == pcount) pcount <= pcount - PCW'(1);
            end else begin
              umap[page] <= umap[page] & ~(UNITS_MAX'(1) << slot);
              used[page] <= used[page] - UW'(1);
            end
          end
        end
        CMD_CLEAR_KEEP: total <= '0;
        CMD_CLEAR_DROP: begin
          total  <= '0;
          pcount <= '0;
        end
        default: ;
      endcase
      res_st <= st_v;
      res_gi <= gi_v;
      res_tk <= tk_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status        <= res_st;
      granted_index <= res_gi;
      slot_taken    <= res_tk;
      total_used    <= total;
      pages_in_use  <= pcount;
    end
  end

endmodule

### sv/paged_bitmap_slot_allocator.sv
`timescale 1ns / 1ps
// Each accepted command passes through the divider, then the page scan (one page
// scanned per cycle) for request or the clear sweep for clears, then execute;
// one command is handled at a time, and a new one is accepted only after the
// result is loaded into the output register. Synchronous active-high reset
// empties the directory and sets units_per_page to 32.
// ----------------------------------------------------------------------------
// paged_bitmap_slot_allocator
// Top level: APB register, sequencer and datapath.
// ----------------------------------------------------------------------------
module paged_bitmap_slot_allocator #(
  parameter int UNITS_MAX = pbsa_pkg::UNITS_MAX_DEF,
  parameter int PAGES_MAX = pbsa_pkg::PAGES_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pbsa_pkg::CMD_W-1:0] cmd,
  input  logic [pbsa_pkg::IDX_W-1:0] index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [pbsa_pkg::IDX_W-1:0] granted_index,
  output logic                       slot_taken,
  output logic [pbsa_pkg::IDX_W:0]   total_used,
  output logic [$clog2(PAGES_MAX+1)-1:0] pages_in_use,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import pbsa_pkg::*;

  logic [UPP_W-1:0] upp_reg;
  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) upp_reg <= UPP_W'(32);
    else if (psel && penable && pwrite && paddr == 2'd0) upp_reg <= pwdata[UPP_W-1:0];
  end

  assign prdata = (paddr == 2'd0) ? {{(32-UPP_W){1'b0}}, upp_reg} : '0;

  pbsa_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .ctl, .sts
  );

  pbsa_dp #(.UNITS_MAX(UNITS_MAX), .PAGES_MAX(PAGES_MAX)) u_dp (
    .clk, .rst, .cmd, .index, .upp_reg, .ctl, .sts, .status, .granted_index,
    .slot_taken, .total_used, .pages_in_use
  );

endmodule
